### hw/rtl/utc_pkg.sv
// Shared types, codes and constants of the Unicode transcoder.
package utc_pkg;

    // Width of a unit, code point or result value
    localparam int UNIT_W = 21;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Mode register codes
    localparam logic [1:0] MODE_UTF8_DEC  = 2'd0;
    localparam logic [1:0] MODE_UTF16_DEC = 2'd1;
    localparam logic [1:0] MODE_UTF8_ENC  = 2'd2;
    localparam logic [1:0] MODE_UTF16_ENC = 2'd3;

    // Queue entry commands for the back end
    localparam logic [1:0] CMD_PASS  = 2'd0;  // one result, value as is
    localparam logic [1:0] CMD_ERR   = 2'd1;  // one error result
    localparam logic [1:0] CMD_UTF8  = 2'd2;  // emit UTF-8 bytes of a code point
    localparam logic [1:0] CMD_UTF16 = 2'd3;  // emit surrogate pair, value is cp - 0x10000

    // Code point limits
    localparam logic [UNIT_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [UNIT_W-1:0] CP_1BYTE   = 21'h00007F;
    localparam logic [UNIT_W-1:0] CP_2BYTE   = 21'h0007FF;
    localparam logic [UNIT_W-1:0] CP_BMP     = 21'h00FFFF;
    localparam logic [UNIT_W-1:0] CP_SUPP    = 21'h010000;
    localparam logic [5:0]        HI_SURR    = 6'b110110;
    localparam logic [5:0]        HI_SURR_OUT = 6'b110110;
    localparam logic [5:0]        LO_SURR_OUT = 6'b110111;

    // One decoded or classified item waiting for the back end
    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        last_idx;  // number of results minus one
        logic [UNIT_W-1:0] value;
    } t_entry;

endpackage

### hw/rtl/utc_if.sv
// Valid/ready channel interfaces for the transcoder input and result streams.
interface utc_in_if;
    import utc_pkg::*;

    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] unit_value;

    modport source (output valid, output unit_value, input ready);
    modport sink   (input valid, input unit_value, output ready);
endinterface

interface utc_out_if;
    import utc_pkg::*;

    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] out_value;
    logic              last_of_run;
    logic              error_flag;

    modport source (output valid, output out_value, output last_of_run,
                    output error_flag, input ready);
    modport sink   (input valid, input out_value, input last_of_run,
                    input error_flag, output ready);
endinterface

### hw/rtl/utc_front.sv
// Front end: accepts items, runs the decode state and classifies each item.
module utc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [1:0]      i_cfg_wr_data,
    utc_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output utc_pkg::t_entry o_entry
);
    import utc_pkg::*;

    logic [1:0]        r_mode;
    logic [1:0]        r_exp;
    logic [UNIT_W-1:0] r_part;
    logic [1:0]        n_exp;
    logic [UNIT_W-1:0] n_part;
    logic              w_acc;
    logic              w_res;
    logic [7:0]        w_byte;
    logic [15:0]       w_unit;
    logic [UNIT_W-1:0] w_cp;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_cp       = i_in.unit_value;
    assign w_byte     = w_cp[7:0];
    assign w_unit     = w_cp[15:0];
    assign o_push     = w_acc && w_res;

    // Classify the item and compute the next decode state
    always_comb begin
        n_exp          = r_exp;
        n_part         = r_part;
        w_res          = 1'b0;
        o_entry.cmd      = CMD_PASS;
        o_entry.last_idx = 2'd0;
        o_entry.value    = '0;
        case (r_mode)
            MODE_UTF8_DEC: begin
                if (r_exp != 2'd0) begin
                    // continuation byte, taken without a check
                    n_part = {r_part[UNIT_W-7:0], w_byte[5:0]};
                    n_exp  = r_exp - 2'd1;
                    if (r_exp == 2'd1) begin
                        w_res         = 1'b1;
                        o_entry.value = n_part;
                    end
                end else if (!w_byte[7]) begin
                    w_res         = 1'b1;
                    o_entry.value = UNIT_W'(w_byte);
                end else if (w_byte[7:5] == 3'b110) begin
                    n_part = UNIT_W'(w_byte[4:0]);
                    n_exp  = 2'd1;
                end else if (w_byte[7:4] == 4'b1110) begin
                    n_part = UNIT_W'(w_byte[3:0]);
                    n_exp  = 2'd2;
                end else if (w_byte[7:3] == 5'b11110) begin
                    n_part = UNIT_W'(w_byte[2:0]);
                    n_exp  = 2'd3;
                end else begin
                    // stray continuation or 11111xxx lead
                    w_res       = 1'b1;
                    o_entry.cmd = CMD_ERR;
                end
            end
            MODE_UTF16_DEC: begin
                if (r_exp != 2'd0) begin
                    // second unit: only its low 10 bits join in
                    w_res         = 1'b1;
                    o_entry.value = (r_part | UNIT_W'(w_unit[9:0])) + CP_SUPP;
                    n_exp         = 2'd0;
                    n_part        = '0;
                end else if (w_unit[15:10] == HI_SURR) begin
                    n_part = UNIT_W'({w_unit[9:0], 10'd0});
                    n_exp  = 2'd1;
                end else begin
                    w_res         = 1'b1;
                    o_entry.value = UNIT_W'(w_unit);
                end
            end
            MODE_UTF8_ENC: begin
                w_res         = 1'b1;
                o_entry.cmd   = CMD_UTF8;
                o_entry.value = w_cp;
                if (w_cp <= CP_1BYTE) begin
                    o_entry.last_idx = 2'd0;
                end else if (w_cp <= CP_2BYTE) begin
                    o_entry.last_idx = 2'd1;
                end else if (w_cp <= CP_BMP) begin
                    o_entry.last_idx = 2'd2;
                end else if (w_cp <= CP_MAX) begin
                    o_entry.last_idx = 2'd3;
                end else begin
                    o_entry.cmd   = CMD_ERR;
                    o_entry.value = '0;
                end
            end
            default: begin
                w_res = 1'b1;
                if (w_cp <= CP_BMP) begin
                    o_entry.value = w_cp;
                end else if (w_cp <= CP_MAX) begin
                    o_entry.cmd      = CMD_UTF16;
                    o_entry.last_idx = 2'd1;
                    o_entry.value    = w_cp - CP_SUPP;
                end else begin
                    o_entry.cmd = CMD_ERR;
                end
            end
        endcase
    end

    // Mode and decode state; a mode write restarts decoding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UTF8_DEC;
            r_exp  <= 2'd0;
            r_part <= '0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
            r_exp  <= 2'd0;
            r_part <= '0;
        end else if (w_acc) begin
            r_exp  <= n_exp;
            r_part <= n_part;
        end
    end

endmodule

### hw/rtl/utc_queue.sv
// Small register queue that decouples the front end from the back end.
module utc_queue #(
    parameter int QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utc_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output utc_pkg::t_entry o_head
);
    import utc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### hw/rtl/utc_back.sv
// Back end: expands entries into results in an output register, one per unstalled cycle
module utc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  utc_pkg::t_entry i_head,
    output logic            o_pop,
    utc_out_if.source       o_out
);
    import utc_pkg::*;

    logic              r_valid;
    logic [1:0]        r_idx;
    logic [UNIT_W-1:0] r_value;
    logic              r_last;
    logic              r_err;
    logic              w_load;
    logic              w_take;
    logic              w_last;
    logic [1:0]        w_rem;
    logic [5:0]        w_six;
    logic [7:0]        w_lead;
    logic [UNIT_W-1:0] w_value;

    assign w_load = !r_valid || o_out.ready;
    assign w_take = w_load && !i_empty;
    assign w_last = (r_idx == i_head.last_idx);
    assign o_pop  = w_take && w_last;
    assign w_rem  = i_head.last_idx - r_idx;

    // Six-bit group and lead byte for the UTF-8 byte still to come
    always_comb begin
        case (w_rem)
            2'd0: begin
                w_six  = i_head.value[5:0];
                w_lead = i_head.value[7:0];
            end
            2'd1: begin
                w_six  = i_head.value[11:6];
                w_lead = {3'b110, i_head.value[10:6]};
            end
            2'd2: begin
                w_six  = i_head.value[17:12];
                w_lead = {4'b1110, i_head.value[15:12]};
            end
            default: begin
                w_six  = {3'd0, i_head.value[20:18]};
                w_lead = {5'b11110, i_head.value[20:18]};
            end
        endcase
    end

    // Result value for the current index of the head entry
    always_comb begin
        case (i_head.cmd)
            CMD_PASS:  w_value = i_head.value;
            CMD_ERR:   w_value = '0;
            CMD_UTF8: begin
                if (r_idx == 2'd0) begin
                    w_value = UNIT_W'(w_lead);
                end else begin
                    w_value = UNIT_W'({2'b10, w_six});
                end
            end
            default: begin
                if (r_idx == 2'd0) begin
                    w_value = UNIT_W'({HI_SURR_OUT, i_head.value[19:10]});
                end else begin
                    w_value = UNIT_W'({LO_SURR_OUT, i_head.value[9:0]});
                end
            end
        endcase
    end

    // Output valid and index within the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (w_take) begin
                r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_value <= w_value;
            r_last  <= w_last;
            r_err   <= (i_head.cmd == CMD_ERR);
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_value   = r_value;
    assign o_out.last_of_run = r_last;
    assign o_out.error_flag  = r_err;

endmodule

### hw/rtl/unicode_transcoder.sv
// Top level of the streaming UTF-8 / UTF-16 / code point transcoder.
// The front end takes one item per cycle whenever the entry queue has room: it updates the
// decode state, classifies the item and queues at most one entry for it. The back end
// turns each entry into one to four results and delivers one result per cycle, while the
// output is not stalled, through an output register; the one-result-per-cycle back end
// sets the sustained rate. An item's entry is written into the queue when the item is
// accepted, and its first result is then loaded from the queue head into the output
// register, from which it can be taken. The queue holds QUEUE_DEPTH entries, which
// lets the input keep flowing while a multi-byte result is still being emitted or the
// output is stalled. The user must write the mode register only while the block is
// empty; the block itself does not enforce this. Each write restarts decoding.
module unicode_transcoder #(
    parameter int QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    utc_in_if.sink     i_in,
    utc_out_if.source  o_out
);
    import utc_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_entry w_entry;
    t_entry w_head;

    utc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    utc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    utc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

### hw/rtl/utc_checker.sv
// Port-level checks on the transcoder result stream, bound to the top level.
module utc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [utc_pkg::UNIT_W-1:0]  i_out_value,
    input logic                        i_out_last,
    input logic                        i_out_err
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        $stable(i_out_value) && $stable(i_out_last) && $stable(i_out_err))
        else $error("result payload changed while stalled");

    // An error result is a single zero result that ends its item
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> (i_out_value == '0) && i_out_last)
        else $error("malformed error result");

    // Reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind unicode_transcoder utc_checker u_utc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.out_value),
    .i_out_last  (o_out.last_of_run),
    .i_out_err   (o_out.error_flag)
);
